### rtl/oqkr_pkg.sv
// ----------------------------------------------------------------------------
// oqkr_pkg
// Shared constants, result codes and controller/datapath link types for the
// ordered queue with keyed removal.
// ----------------------------------------------------------------------------
`default_nettype none

package oqkr_pkg;

  // Default sizing
  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_ID_WIDTH    = 16;

  // Status field
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  // Operation codes carried on the input tuser
  localparam logic OP_ENQ    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;    // capture the key, restart the read pointer
    logic enq;     // append at the tail or report full
    logic scan;    // issue a search read and compare
    logic shift;   // move one entry down and issue the next read
    logic absent;  // post a not-found result
    logic finish;  // drop one entry, post the removed word
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic hit;        // compared entry equals the key
    logic exhausted;  // every held entry has been read and checked
    logic pend;       // a read word is waiting in the read register
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/oqkr_datapath.sv
// ----------------------------------------------------------------------------
// oqkr_datapath
// Entry memory, count, read/write pointers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module oqkr_datapath import oqkr_pkg::*; #(
  parameter  int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter  int ID_WIDTH    = DEF_ID_WIDTH,
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1),
  localparam int AW          = $clog2(QUEUE_DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [ID_WIDTH-1:0] in_key,
  input  wire dp_cmd_t             cmd,
  output dp_sts_t                  sts,
  output logic      [ID_WIDTH-1:0] res_removed,
  output logic      [STATUS_W-1:0] res_status,
  output logic      [CNT_W-1:0]    res_count
);

  logic [ID_WIDTH-1:0] mem [QUEUE_DEPTH];

  logic [ID_WIDTH-1:0] key_r;
  logic [ID_WIDTH-1:0] rd_data_r;
  logic [ID_WIDTH-1:0] removed_r;
  logic [CNT_W-1:0]    count_r,  count_nxt;
  logic [CNT_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    pos_r,    pos_nxt;
  logic [CNT_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic                pend_r,   pend_nxt;

  logic                full;
  logic                hit;
  logic                rd_en;
  logic                wr_en;
  logic [CNT_W-1:0]    wr_addr;
  logic [ID_WIDTH-1:0] wr_data;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign hit   = pend_r && (rd_data_r == key_r);
  assign rd_en = (cmd.scan || cmd.shift) && (rd_ptr_r < count_r);

  assign sts.hit       = hit;
  assign sts.exhausted = !pend_r && (rd_ptr_r == count_r);
  assign sts.pend      = pend_r;

  // Write port: tail append, or close up one slot during the shift
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r;
    wr_data = key_r;
    if (cmd.enq && !full) begin
      wr_en = 1'b1;
    end else if (cmd.shift && pend_r) begin
      wr_en   = 1'b1;
      wr_addr = wr_ptr_r;
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_ptr_r[AW-1:0]];
    end
  end

  // Pointer and count updates
  always_comb begin
    count_nxt  = count_r;
    rd_ptr_nxt = rd_ptr_r;
    pos_nxt    = pos_r;
    wr_ptr_nxt = wr_ptr_r;
    pend_nxt   = pend_r;
    if (cmd.load) begin
      rd_ptr_nxt = '0;
      pend_nxt   = 1'b0;
    end
    if (cmd.scan || cmd.shift) begin
      pend_nxt = rd_en;
      if (rd_en) begin
        rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
        pos_nxt    = rd_ptr_r;
      end
    end
    if (cmd.scan && hit) begin
      wr_ptr_nxt = pos_r;
    end
    if (cmd.shift && pend_r) begin
      wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
    end
    if (cmd.enq && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.finish) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_ptr_r <= '0;
      pos_r    <= '0;
      wr_ptr_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      pos_r    <= pos_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      pend_r   <= pend_nxt;
    end
  end

  // Key, removed word and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key;
    end
    if (cmd.scan && hit) begin
      removed_r <= rd_data_r;
    end
    if (cmd.enq) begin
      res_removed <= '0;
      res_status  <= full ? ST_FULL : ST_OK;
      res_count   <= count_nxt;
    end
    if (cmd.absent) begin
      res_removed <= '0;
      res_status  <= ST_ABSENT;
      res_count   <= count_r;
    end
    if (cmd.finish) begin
      res_removed <= removed_r;
      res_status  <= ST_OK;
      res_count   <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (count_r == $past(count_r) ||
               count_r == $past(count_r) + CNT_W'(1) ||
               count_r == $past(count_r) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (pos_r < count_r))
    else $error("read word beyond held entries");

endmodule

`default_nettype wire

### rtl/oqkr_ctrl.sv
// ----------------------------------------------------------------------------
// oqkr_ctrl
// Sequencer for enqueue, search and close-up; owns the stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module oqkr_ctrl import oqkr_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire logic    in_op,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENQ   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_RESP);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_op == OP_ENQ) ? S_ENQ : S_SCAN;
        end
      end
      S_ENQ: begin
        cmd.enq   = 1'b1;
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = S_SHIFT;
        end else if (sts.exhausted) begin
          cmd.absent = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (!sts.pend) begin
          cmd.finish = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_enq_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_op == OP_ENQ) |=> (state_r == S_ENQ))
    else $error("enqueue word did not reach the append step");

  a_hit_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.hit) |=> (state_r == S_SHIFT))
    else $error("match found but close-up not started");

  a_shift_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |=> (state_r == S_SHIFT || state_r == S_RESP))
    else $error("close-up left to an unexpected state");

endmodule

`default_nettype wire

### rtl/ordered_queue_keyed_removal.sv
// Throughput: one word at a time; the next word can be taken in the cycle
//   after the result is taken. The search and close-up walk the entry memory
//   one entry per cycle.
// Reset: synchronous, active low; empties the queue, memory contents stay.
// ----------------------------------------------------------------------------
// ordered_queue_keyed_removal
// Ordered queue of thread identifiers with tail append and removal of the
// first matching entry, closing up the gap in order.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_queue_keyed_removal import oqkr_pkg::*; #(
  parameter  int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter  int ID_WIDTH    = DEF_ID_WIDTH,
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_TDATA_W  = ((ID_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((ID_WIDTH + STATUS_W + CNT_W + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input channel
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // item_value, zero pad
  input  wire logic                   in_tuser,   // op
  // Result channel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata   // removed_value, status,
                                                  // entry_count, zero pad
);

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [ID_WIDTH-1:0] res_removed;
  logic [STATUS_W-1:0] res_status;
  logic [CNT_W-1:0]    res_count;

  // Sequencer: takes one word, walks it through append or search/close-up,
  // then holds the result until the sink takes it.
  oqkr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Entry memory with one write and one registered read port, plus the
  // count, pointers and result register.
  oqkr_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_key      (in_tdata[ID_WIDTH-1:0]),
    .cmd         (cmd),
    .sts         (sts),
    .res_removed (res_removed),
    .res_status  (res_status),
    .res_count   (res_count)
  );

  // Pack the result word, lowest field first, zero fill to whole bytes
  assign out_tdata = OUT_TDATA_W'({res_count, res_status, res_removed});

endmodule

`default_nettype wire
